// ----- sv/hls_pkg.sv -----
// hls_pkg: shared constants, function codes and the logistic table helpers
// for the hashed logistic scorer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hls_pkg;

	// weight store geometry
	localparam int TABLE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = ADDR_W + 1;

	// item fields
	localparam int FUNC_W   = 2;
	localparam int HASH_W   = 64;
	localparam int INDEX_W  = 16;
	localparam int WEIGHT_W = 24;
	localparam int CFG_W    = 17;
	localparam int PROB_W   = 16;

	// accumulator, Q15.16
	localparam int SUM_W = 32;

	// logistic table, entry k stands for x = -16 + k/256
	localparam int LOGI_ENTRIES = 8192;
	localparam int LOGI_HALF    = 4096;
	localparam int LOGI_AW      = $clog2(LOGI_ENTRIES);
	localparam int LOGI_SHIFT   = 8;

	// reset value of the table size register
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

	// shift-subtract quotient, table fill use only
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			q = {q[62:0], 1'b0};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// (a * b) >> 60
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	// round(65536 * num / den), capped at 65535
	function automatic logic [PROB_W-1:0] ratio_q16(input logic [63:0] num,
			input logic [63:0] den);
		logic [63:0] r;
		logic [PROB_W:0] q;
		r = num;
		q = '0;
		if (r >= den) begin
			return {PROB_W{1'b1}};
		end
		for (int i = 0; i < PROB_W; i++) begin
			r = r << 1;
			q = {q[PROB_W-1:0], 1'b0};
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		if (r >= den - r) begin
			q = q + 1'b1;
		end
		if (q[PROB_W]) begin
			return {PROB_W{1'b1}};
		end
		return q[PROB_W-1:0];
	endfunction

	// e^(-1/256) in Q60 by Taylor series, truncated terms
	function automatic logic [63:0] exp_step();
		logic [63:0] step;
		logic [63:0] term;
		logic [63:0] n;
		logic sub;
		step = ONE_Q60;
		term = ONE_Q60;
		n    = 64'd1;
		sub  = 1'b1;
		for (int i = 0; i < 64; i++) begin
			if (term != 64'd0) begin
				term = div_u64(term >> 8, n);
				step = sub ? step - term : step + term;
				sub  = !sub;
				n    = n + 64'd1;
			end
		end
		return step;
	endfunction

endpackage

`default_nettype wire

// ----- sv/hashed_logistic_score.sv -----
// hashed_logistic_score: top level, sequencer and Q15.16 accumulator.
// Depends on hls_pkg, hls_mod_unit, hls_ram, hls_logi_rom.
//
// Usage: an item is taken when start is high and busy is low; func selects
// load weight, add feature hash or finish. cfg_write/cfg_data set the table
// size; the user writes them only while busy is low and no score is pending;
// the block does not enforce this. Load: written into the weight store on the
//   accept edge; busy stays low, so a new item may follow in the next cycle.
// Add feature: the 64-bit hash goes through a bit-serial remainder unit,
//   64 steps, then a weight read and an accumulate step; busy stays high
//   until the accumulate is done, so no new item is taken meanwhile.
// Finish: score_valid pulses for one cycle, the cycle after the accept
//   edge, with click_probability and sum_saturated; busy is high meanwhile.
//   The accumulator and its saturation flag clear on the accept edge.
// The receiver cannot stall; each score is shown exactly once.
// Reset clears the accumulator, the flag and the sequencer and sets the
// table size to 65536; weight store contents are undefined until loaded.
// Unused func code 3 is taken and ignored.
`timescale 1ns / 1ps
`default_nettype none

module hashed_logistic_score (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [hls_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [hls_pkg::FUNC_W-1:0]          func,
	input  wire logic [hls_pkg::HASH_W-1:0]          feature_hash,
	input  wire logic [hls_pkg::INDEX_W-1:0]         weight_index,
	input  wire logic signed [hls_pkg::WEIGHT_W-1:0] weight_value,
	output logic                                     score_valid,
	output logic [hls_pkg::PROB_W-1:0]               click_probability,
	output logic                                     sum_saturated
);

	localparam int SIZE_W  = hls_pkg::SIZE_W;
	localparam int ADDR_W  = hls_pkg::ADDR_W;
	localparam int CMP_W   = (hls_pkg::CFG_W > SIZE_W) ? hls_pkg::CFG_W : SIZE_W;
	localparam int IDX_CW  = (hls_pkg::INDEX_W > SIZE_W) ? hls_pkg::INDEX_W + 1 : SIZE_W + 1;
	localparam int SUM_W   = hls_pkg::SUM_W;
	localparam int SH_W    = SUM_W - hls_pkg::LOGI_SHIFT;
	localparam int KIDX_W  = SH_W + 1;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_ACC  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]                 state_q;
	logic [hls_pkg::CFG_W-1:0]  size_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       sat_q;
	logic                       sat_out_q;

	logic                       accept;
	logic [SIZE_W-1:0]          size_use;
	logic                       wr_ok;
	logic                       div_done;
	logic [SIZE_W-1:0]          residue;
	logic [ADDR_W-1:0]          slot;
	logic [hls_pkg::WEIGHT_W-1:0] weight_rd;
	logic signed [SUM_W:0]      sum_wide;
	logic signed [SUM_W-1:0]    sum_next;
	logic                       sat_hit;
	logic signed [SH_W-1:0]     sum_sh;
	logic signed [KIDX_W-1:0]   kidx;
	logic [hls_pkg::LOGI_AW-1:0] rom_addr;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= hls_pkg::CFG_RESET;
		end else if (cfg_write) begin
			size_q <= cfg_data;
		end
	end

	// size in use: zero acts as one, oversize clamps to the store depth
	always_comb begin
		if (size_q == '0) begin
			size_use = SIZE_W'(1);
		end else if (CMP_W'(size_q) > CMP_W'(hls_pkg::TABLE_DEPTH)) begin
			size_use = SIZE_W'(hls_pkg::TABLE_DEPTH);
		end else begin
			size_use = SIZE_W'(size_q);
		end
	end

	// loads beyond the store are dropped
	assign wr_ok = (IDX_CW'(weight_index) < IDX_CW'(hls_pkg::TABLE_DEPTH));

	hls_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept && (func == hls_pkg::FUNC_ADD)),
		.dividend (feature_hash),
		.divisor  (size_use),
		.done     (div_done),
		.residue  (residue)
	);

	// residue zero wraps to the last entry in use
	always_comb begin
		if (residue == '0) begin
			slot = ADDR_W'(size_use - 1'b1);
		end else begin
			slot = ADDR_W'(residue - 1'b1);
		end
	end

	hls_ram #(
		.DEPTH (hls_pkg::TABLE_DEPTH),
		.WIDTH (hls_pkg::WEIGHT_W)
	) u_wstore (
		.clk     (clk),
		.wr_en   (accept && (func == hls_pkg::FUNC_LOAD) && wr_ok),
		.wr_addr (ADDR_W'(weight_index)),
		.wr_data (weight_value),
		.rd_en   ((state_q == S_DIV) && div_done),
		.rd_addr (slot),
		.rd_data (weight_rd)
	);

	// saturating accumulate
	always_comb begin
		sum_wide = {sum_q[SUM_W-1], sum_q}
			+ (SUM_W+1)'(signed'(weight_rd));
		sat_hit  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]);
		if (sat_hit) begin
			sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
				: {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
	end

	// lookup index: floor(sum / 256) + half, clamped to the table
	always_comb begin
		sum_sh = sum_q[SUM_W-1:hls_pkg::LOGI_SHIFT];
		kidx   = KIDX_W'(sum_sh) + KIDX_W'(hls_pkg::LOGI_HALF);
		if (kidx < 0) begin
			rom_addr = '0;
		end else if (kidx > KIDX_W'(hls_pkg::LOGI_ENTRIES - 1)) begin
			rom_addr = '1;
		end else begin
			rom_addr = kidx[hls_pkg::LOGI_AW-1:0];
		end
	end

	hls_logi_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (click_probability)
	);

	// sequencer and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sum_q     <= '0;
			sat_q     <= 1'b0;
			sat_out_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (func == hls_pkg::FUNC_ADD)) begin
						state_q <= S_DIV;
					end else if (accept && (func == hls_pkg::FUNC_FINISH)) begin
						sat_out_q <= sat_q;
						sum_q     <= '0;
						sat_q     <= 1'b0;
						state_q   <= S_EMIT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					sum_q <= sum_next;
					if (sat_hit) begin
						sat_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign score_valid   = (state_q == S_EMIT);
	assign sum_saturated = sat_out_q;

endmodule

`default_nettype wire

// ----- sv/hls_mod_unit.sv -----
// hls_mod_unit: bit-serial remainder of a 64-bit hash by the table size,
// one restoring step per cycle. Depends on hls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hls_mod_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [hls_pkg::HASH_W-1:0]    dividend,
	input  wire logic [hls_pkg::SIZE_W-1:0]    divisor,
	output logic                               done,
	output logic [hls_pkg::SIZE_W-1:0]         residue
);

	localparam int CNT_W = $clog2(hls_pkg::HASH_W);

	logic [hls_pkg::HASH_W-1:0] dvd_q;
	logic [hls_pkg::SIZE_W-1:0] dsr_q;
	logic [hls_pkg::SIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       run_q;
	logic                       done_q;

	logic [hls_pkg::SIZE_W:0]   trial;
	logic [hls_pkg::SIZE_W:0]   diff;
	logic [hls_pkg::SIZE_W-1:0] rem_next;
	logic                       last;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[hls_pkg::HASH_W-1]};
		diff  = trial - {1'b0, dsr_q};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = diff[hls_pkg::SIZE_W-1:0];
		end else begin
			rem_next = trial[hls_pkg::SIZE_W-1:0];
		end
		last = (cnt_q == CNT_W'(hls_pkg::HASH_W - 1));
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[hls_pkg::HASH_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done    = done_q;
	assign residue = rem_q;

endmodule

`default_nettype wire

// ----- sv/hls_ram.sv -----
// hls_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hls_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ----- sv/hls_logi_rom.sv -----
// hls_logi_rom: logistic lookup ROM, 8192 Q0.16 entries, registered read.
// Contents are filled at time zero with the hls_pkg table helpers.
`timescale 1ns / 1ps
`default_nettype none

module hls_logi_rom (
	input  wire logic                         clk,
	input  wire logic [hls_pkg::LOGI_AW-1:0]  addr,
	output logic [hls_pkg::PROB_W-1:0]        data
);

	logic [hls_pkg::PROB_W-1:0] rom [hls_pkg::LOGI_ENTRIES];
	logic [hls_pkg::PROB_W-1:0] data_q;

	// walk p = e^(-j/256) outward from x = 0, both halves at once
	initial begin : fill
		logic [63:0] step;
		logic [63:0] p;
		logic [63:0] den;
		step = hls_pkg::exp_step();
		p    = hls_pkg::ONE_Q60;
		for (int j = 0; j <= hls_pkg::LOGI_HALF; j++) begin
			den = hls_pkg::ONE_Q60 + p;
			if (j < hls_pkg::LOGI_HALF) begin
				rom[hls_pkg::LOGI_HALF + j] = hls_pkg::ratio_q16(hls_pkg::ONE_Q60, den);
			end
			if (j >= 1) begin
				rom[hls_pkg::LOGI_HALF - j] = hls_pkg::ratio_q16(p, den);
			end
			p = hls_pkg::mul_q60(p, step);
		end
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ----- sv/hls_checker.sv -----
// hls_checker: port-level assertions for hashed_logistic_score, attached
// by the bind below. Depends on hls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hls_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic [hls_pkg::FUNC_W-1:0] func,
	input  wire logic                       score_valid
);

	// a score comes in the cycle after its finish item is taken
	a_emit_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid |-> $past(start) && !$past(busy)
			&& ($past(func) == hls_pkg::FUNC_FINISH))
		else $error("score without a finish item one cycle before");

	// a finish item always yields its score in the next cycle
	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == hls_pkg::FUNC_FINISH) |=> score_valid)
		else $error("finish item gave no score");

	// score strobe lasts one cycle and the block is free afterwards
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid |=> !score_valid && !busy)
		else $error("score strobe longer than one cycle");

	// loads and unused codes never make the block busy
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func != hls_pkg::FUNC_ADD)
			&& (func != hls_pkg::FUNC_FINISH) |=> !busy)
		else $error("load or unused item made the block busy");

endmodule

bind hashed_logistic_score hls_checker u_hls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.func        (func),
	.score_valid (score_valid)
);

`default_nettype wire

// ----- verif/hls_score_checker.sv -----
// hls_score_checker: watches the config, item and score ports of the hashed
// logistic scorer, predicts every score and compares it. Depends on hls_pkg.
`timescale 1ns / 1ps

module hls_score_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [hls_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                start,
	input  logic                                busy,
	input  logic [hls_pkg::FUNC_W-1:0]          func,
	input  logic [hls_pkg::HASH_W-1:0]          feature_hash,
	input  logic [hls_pkg::INDEX_W-1:0]         weight_index,
	input  logic signed [hls_pkg::WEIGHT_W-1:0] weight_value,
	input  logic                                score_valid,
	input  logic [hls_pkg::PROB_W-1:0]          click_probability,
	input  logic                                sum_saturated,
	output int                                  mismatches,
	output int                                  scores_owed
);
	import hls_pkg::*;

	localparam longint ACC_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint ACC_MIN = -(longint'(1) <<< (SUM_W - 1));

	typedef struct packed {
		logic [PROB_W-1:0] prob;
		logic              clipped;
	} score_t;

	// predictor state
	logic signed [WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];
	logic signed [SUM_W-1:0]    acc;
	logic                       acc_clipped;
	logic [CFG_W-1:0]           size_reg;
	logic [PROB_W-1:0]          logistic_lut [LOGI_ENTRIES];
	score_t                     score_fifo [$];

	// per-item scratch
	logic [CFG_W-1:0]  span;
	logic [HASH_W-1:0] residue;
	logic [ADDR_W-1:0] slot;
	longint            wide_sum;
	int                lut_k;
	score_t            want;
	int                errors = 0;

	// round(65536 * num / den), capped at 65535
	function automatic logic [PROB_W-1:0] q16_ratio(input logic [63:0] num,
			input logic [63:0] den);
		logic [127:0] scaled;
		logic [127:0] quot;
		logic [127:0] rem;
		if (num >= den) begin
			return '1;
		end
		scaled = {64'd0, num} << PROB_W;
		quot   = scaled / den;
		rem    = scaled % den;
		if (rem >= den - rem) begin
			quot = quot + 1;
		end
		return (quot > 128'd65535) ? '1 : quot[PROB_W-1:0];
	endfunction

	// logistic lookup, filled once: entry k is 1/(1+e^-x) at x = -16 + k/256
	initial begin : build_lut
		logic [63:0]  decay;
		logic [63:0]  term;
		logic [63:0]  pw;
		logic [63:0]  divisor;
		logic [127:0] prod;
		bit           minus;
		decay   = ONE_Q60;
		term    = ONE_Q60;
		pw      = ONE_Q60;
		divisor = 64'd1;
		minus   = 1'b1;
		// e^(-1/256) in Q60, alternating series, truncated terms
		while (term != 0) begin
			term    = (term >> LOGI_SHIFT) / divisor;
			decay   = minus ? decay - term : decay + term;
			minus   = !minus;
			divisor = divisor + 1;
		end
		// pw = e^(-j/256), both halves of the curve at once
		for (int j = 0; j <= LOGI_HALF; j++) begin
			if (j < LOGI_HALF) begin
				logistic_lut[LOGI_HALF + j] = q16_ratio(ONE_Q60, ONE_Q60 + pw);
			end
			if (j >= 1) begin
				logistic_lut[LOGI_HALF - j] = q16_ratio(pw, ONE_Q60 + pw);
			end
			prod = {64'd0, pw} * {64'd0, decay};
			pw   = prod[123:60];
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc         = '0;
			acc_clipped = 1'b0;
			size_reg    = CFG_RESET;
			score_fifo.delete();
			mismatches  <= errors;
			scores_owed <= 0;
		end else begin
			// score side first: a finish taken at this edge scores in the next cycle
			if (score_valid) begin
				if (score_fifo.size() == 0) begin
					$display("%0t: score expected none, got click_probability %0d sum_saturated %0d",
						$time, click_probability, sum_saturated);
					errors++;
				end else begin
					want = score_fifo.pop_front();
					if (click_probability !== want.prob) begin
						$display("%0t: click_probability expected %0d, got %0d",
							$time, want.prob, click_probability);
						errors++;
					end
					if (sum_saturated !== want.clipped) begin
						$display("%0t: sum_saturated expected %0d, got %0d",
							$time, want.clipped, sum_saturated);
						errors++;
					end
				end
			end

			if (cfg_write) begin
				size_reg = cfg_data;
			end

			// accepted item
			if (start && !busy) begin
				case (func)
					FUNC_LOAD: begin
						weight_mem[weight_index] = weight_value;
					end
					FUNC_ADD: begin
						// zero acts as one, oversize clips to the store depth
						span = (size_reg == '0) ? CFG_W'(1) :
							(size_reg > CFG_W'(TABLE_DEPTH)) ? CFG_W'(TABLE_DEPTH) : size_reg;
						residue = feature_hash % HASH_W'(span);
						// residue zero wraps to the last entry in use
						slot = (residue == 0) ? ADDR_W'(span - 1'b1) : ADDR_W'(residue - 1);
						wide_sum = longint'(acc) + longint'(weight_mem[slot]);
						if (wide_sum > ACC_MAX) begin
							acc         = SUM_W'(ACC_MAX);
							acc_clipped = 1'b1;
						end else if (wide_sum < ACC_MIN) begin
							acc         = SUM_W'(ACC_MIN);
							acc_clipped = 1'b1;
						end else begin
							acc = SUM_W'(wide_sum);
						end
					end
					FUNC_FINISH: begin
						lut_k = int'(acc >>> LOGI_SHIFT) + LOGI_HALF;
						if (lut_k < 0) begin
							lut_k = 0;
						end else if (lut_k > LOGI_ENTRIES - 1) begin
							lut_k = LOGI_ENTRIES - 1;
						end
						want.prob    = logistic_lut[lut_k];
						want.clipped = acc_clipped;
						score_fifo.push_back(want);
						acc         = '0;
						acc_clipped = 1'b0;
					end
					default: begin
						// spare code: no effect
					end
				endcase
			end

			mismatches  <= errors;
			scores_owed <= score_fifo.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
// testbench: clock, reset, item stimulus and verdict for hashed_logistic_score.
// Depends on hls_pkg, the block itself and hls_score_checker.
`timescale 1ns / 1ps

module testbench;
	import hls_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASE_ITEMS   = 24;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_write;
	logic [CFG_W-1:0]           cfg_data;
	logic                       start;
	logic                       busy;
	logic [FUNC_W-1:0]          func;
	logic [HASH_W-1:0]          feature_hash;
	logic [INDEX_W-1:0]         weight_index;
	logic signed [WEIGHT_W-1:0] weight_value;
	logic                       score_valid;
	logic [PROB_W-1:0]          click_probability;
	logic                       sum_saturated;
	int                         mismatches;
	int                         scores_owed;

	// stimulus bookkeeping
	bit                loaded [TABLE_DEPTH];
	logic [CFG_W-1:0]  size_now;
	bit                steady;
	int                items_sent;
	logic [HASH_W-1:0] hash_pool [$];

	hashed_logistic_score dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_data          (cfg_data),
		.start             (start),
		.busy              (busy),
		.func              (func),
		.feature_hash      (feature_hash),
		.weight_index      (weight_index),
		.weight_value      (weight_value),
		.score_valid       (score_valid),
		.click_probability (click_probability),
		.sum_saturated     (sum_saturated)
	);

	hls_score_checker score_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_data          (cfg_data),
		.start             (start),
		.busy              (busy),
		.func              (func),
		.feature_hash      (feature_hash),
		.weight_index      (weight_index),
		.weight_value      (weight_value),
		.score_valid       (score_valid),
		.click_probability (click_probability),
		.sum_saturated     (sum_saturated),
		.mismatches        (mismatches),
		.scores_owed       (scores_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// store entry a hash lands on under the current table size
	function automatic logic [INDEX_W-1:0] slot_for(input logic [HASH_W-1:0] h);
		logic [CFG_W-1:0]  span;
		logic [HASH_W-1:0] res;
		span = (size_now == '0) ? CFG_W'(1) :
			(size_now > CFG_W'(TABLE_DEPTH)) ? CFG_W'(TABLE_DEPTH) : size_now;
		res = h % HASH_W'(span);
		return (res == 0) ? INDEX_W'(span - 1'b1) : INDEX_W'(res - 1);
	endfunction

	function automatic logic [HASH_W-1:0] rand_hash();
		return {$urandom, $urandom};
	endfunction

	// full range, small, near the limits, or moderate
	function automatic logic signed [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 3))
			0: return WEIGHT_W'($urandom);
			1: return WEIGHT_W'(int'($urandom_range(0, 1023)) - 512);
			2: return $urandom_range(0, 1) ? WEIGHT_W'(24'h7FFFFF - $urandom_range(0, 255)) :
				WEIGHT_W'(24'h800000 + $urandom_range(0, 255));
			default: return WEIGHT_W'(int'($urandom_range(0, 524287)) - 262144);
		endcase
	endfunction

	// recent hashes, random ones, and ones with residue zero
	function automatic logic [HASH_W-1:0] pick_hash();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick < 6 && hash_pool.size() != 0) begin
			return hash_pool[$urandom_range(0, hash_pool.size() - 1)];
		end
		if (pick == 6) begin
			return '0;
		end
		if (pick == 7) begin
			return '1;
		end
		if (pick == 8) begin
			return HASH_W'(size_now) * HASH_W'($urandom_range(0, 1000));
		end
		return rand_hash();
	endfunction

	// one item: optional idle, then hold start until busy is low at an edge
	task automatic drive_item(input logic [FUNC_W-1:0] f, input logic [HASH_W-1:0] h,
			input logic [INDEX_W-1:0] idx, input logic signed [WEIGHT_W-1:0] w);
		if (!steady) begin
			if ($urandom_range(0, 19) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 90)) @(negedge clk);
			end
			while ($urandom_range(0, 99) < 38) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start        <= 1'b1;
		func         <= f;
		feature_hash <= h;
		weight_index <= idx;
		weight_value <= w;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		if (f != FUNC_SPARE) begin
			items_sent++;
		end
	endtask

	task automatic load_weight(input logic [INDEX_W-1:0] idx,
			input logic signed [WEIGHT_W-1:0] w);
		drive_item(FUNC_LOAD, rand_hash(), idx, w);
		loaded[idx] = 1'b1;
	endtask

	// never read an entry that was not loaded: load it first
	task automatic add_feature(input logic [HASH_W-1:0] h);
		logic [INDEX_W-1:0] slot;
		slot = slot_for(h);
		if (!loaded[slot]) begin
			load_weight(slot, rand_weight());
		end
		drive_item(FUNC_ADD, h, INDEX_W'($urandom), WEIGHT_W'($urandom));
		hash_pool.push_back(h);
		if (hash_pool.size() > 16) begin
			void'(hash_pool.pop_front());
		end
	endtask

	task automatic finish_request();
		drive_item(FUNC_FINISH, rand_hash(), INDEX_W'($urandom), WEIGHT_W'($urandom));
	endtask

	// wait out pending scores, then the longest feature latency
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (scores_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_table_size(input logic [CFG_W-1:0] v);
		settle();
		cfg_write <= 1'b1;
		cfg_data  <= v;
		size_now  = v;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// drive the sum past a limit with a near-extreme weight, then pull back
	task automatic saturate(input bit upward);
		logic signed [WEIGHT_W-1:0] big;
		big = upward ? WEIGHT_W'(24'h7FFFFF - $urandom_range(0, 999)) :
			WEIGHT_W'(24'h800000 + $urandom_range(0, 999));
		load_weight(slot_for(64'd0), big);
		repeat ($urandom_range(258, 270)) add_feature(rand_hash());
		load_weight(slot_for(64'd0), upward ? -WEIGHT_W'(300) : WEIGHT_W'(300));
		repeat (2) add_feature(rand_hash());
		finish_request();
		// flag must be clear again
		finish_request();
	endtask

	// mostly well-formed requests, some noise and dangling features
	task automatic run_requests(input int budget);
		int stop_at;
		int pick;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				drive_item(FUNC_SPARE, rand_hash(), INDEX_W'($urandom), WEIGHT_W'($urandom));
			end else if (pick < 18) begin
				load_weight(INDEX_W'($urandom), rand_weight());
			end else if (pick < 21) begin
				finish_request();
			end else if (pick < 25) begin
				add_feature(pick_hash());
			end else begin
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 9) == 0) begin
						load_weight(INDEX_W'($urandom), rand_weight());
					end
					add_feature(pick_hash());
				end
				finish_request();
			end
		end
	endtask

	// hang detector: nothing taken for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || score_valid) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_data     = '0;
		start        = 1'b0;
		func         = FUNC_LOAD;
		feature_hash = '0;
		weight_index = '0;
		weight_value = '0;
		steady       = 1'b0;
		items_sent   = 0;
		size_now     = CFG_RESET;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, table size at its reset value
		finish_request();                      // empty request
		load_weight(16'h0000, 24'h7FFFFF);
		load_weight(16'hFFFF, 24'h800000);
		load_weight(16'hFFFE, 24'h555555);
		load_weight(16'hAAAA, 24'hAAAAAA);
		load_weight(16'h0001, 24'hFFFFFF);
		add_feature(64'd0);                    // residue zero: last entry
		add_feature('1);
		add_feature(64'd1);
		drive_item(FUNC_SPARE, '1, '1, '1);    // spare code, ignored
		finish_request();
		add_feature(64'hAAAA_AAAA_AAAA_AAAB);
		add_feature(64'h5555_5555_5555_0001);
		finish_request();
		add_feature(64'd2);                    // small negative sum
		finish_request();
		add_feature(64'h8000_0000_0000_0000);
		finish_request();

		// random phases over a range of table sizes
		set_table_size(CFG_W'(1));
		saturate(1'b1);
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(0));
		saturate(1'b0);
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(65536));
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(2));
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(3));
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(65535));
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(65537));
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(131071));
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'(1000));
		run_requests(PHASE_ITEMS);
		set_table_size(CFG_W'($urandom_range(4, 65535)));
		run_requests(PHASE_ITEMS);
		// back-to-back stretch
		set_table_size(CFG_W'(7));
		steady = 1'b1;
		run_requests(PHASE_ITEMS);
		steady = 1'b0;

		settle();
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/hls_pkg.sv
sv/hls_mod_unit.sv
sv/hls_ram.sv
sv/hls_logi_rom.sv
sv/hashed_logistic_score.sv
sv/hls_checker.sv
verif/hls_score_checker.sv
verif/testbench.sv
